// ===== hw/rtl/gqv_pkg.sv =====
// ----------------------------------------------------------------------------
// gqv_pkg: shared types and constants of the glyph quad vertex generator
// Item, glyph table entry, quad descriptor and vertex layouts, character
// codes, corner codes, register indexes and position saturation.
// ----------------------------------------------------------------------------
package gqv_pkg;

  // Operation codes of an input request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // Configuration register indexes
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_COLOR = 1'b1;

  // Character codes
  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd127;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] CR_CODE      = 8'd13;
  localparam logic [7:0] SUBST_IDX    = 8'd31;   // '?' minus first printable code

  // Fixed-point constants (Q.4)
  localparam logic signed [12:0] TOP_SHIFT_Q4 = 13'sd448;   // 28.0

  // Corner codes, emitted in this order
  localparam logic [2:0] CORNER_TL  = 3'd0;
  localparam logic [2:0] CORNER_BL  = 3'd1;
  localparam logic [2:0] CORNER_TR  = 3'd2;
  localparam logic [2:0] CORNER_TR2 = 3'd3;
  localparam logic [2:0] CORNER_BL2 = 3'd4;
  localparam logic [2:0] CORNER_BR  = 3'd5;

  // Quad queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [23:0] POS_MAX = 24'sd524287;
  localparam logic signed [23:0] POS_MIN = -24'sd524288;

  typedef struct packed {
    logic               operation;
    logic [7:0]         char_code;
    logic               first_of_string;
    logic signed [19:0] origin_x;
    logic signed [19:0] origin_y;
    logic [10:0]        atlas_x0;
    logic [10:0]        atlas_y0;
    logic [10:0]        atlas_x1;
    logic [10:0]        atlas_y1;
    logic signed [11:0] offset_x;
    logic signed [11:0] offset_y;
    logic [11:0]        advance;
  } item_t;

  typedef struct packed {
    logic [10:0]        ax0;
    logic [10:0]        ay0;
    logic [10:0]        ax1;
    logic [10:0]        ay1;
    logic signed [11:0] off_x;
    logic signed [11:0] off_y;
    logic [11:0]        adv;
  } glyph_t;

  typedef struct packed {
    logic signed [19:0] x0;
    logic signed [19:0] y0;
    logic signed [19:0] x1;
    logic signed [19:0] y1;
    logic [10:0]        ax0;
    logic [10:0]        ay0;
    logic [10:0]        ax1;
    logic [10:0]        ay1;
  } quad_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [10:0]        tex_u;
    logic [10:0]        tex_v;
    logic [31:0]        color;
    logic [2:0]         corner_index;
    logic               last;
  } vertex_t;

  function automatic logic signed [19:0] sat_pos(input logic signed [23:0] v);
    logic signed [19:0] r;
    if (v > POS_MAX) begin
      r = 20'sh7FFFF;
    end else if (v < POS_MIN) begin
      r = 20'sh80000;
    end else begin
      r = 20'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gqv_ram.sv =====
// ----------------------------------------------------------------------------
// gqv_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module gqv_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 96,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/gqv_front.sv =====
// ----------------------------------------------------------------------------
// gqv_front: request intake, glyph table and quad geometry
// Buffers one request, writes table loads, tracks the pen, and turns each text
// byte but newline and CR into a saturated quad descriptor for the quad queue.
// ----------------------------------------------------------------------------
module gqv_front import gqv_pkg::*; #(
  parameter int GLYPH_COUNT = 96,
  parameter int ATLAS_SIZE  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  item_t       in_item,
  input  logic [11:0] scale,
  input  logic        q_full,
  output logic        q_push,
  output quad_t       q_quad
);
  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  function automatic logic [10:0] clamp_atlas(input logic [10:0] v);
    return (int'(v) > ATLAS_SIZE) ? 11'(ATLAS_SIZE) : v;
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic               ibuf_vld_r, ibuf_vld_nxt;
  item_t              ibuf_r;
  logic signed [19:0] pen_x_r, pen_x_nxt;
  logic signed [19:0] pen_y_r, pen_y_nxt;
  logic signed [19:0] line_x_r, line_x_nxt;
  logic               zero_r, zero_nxt;

  logic               take;
  logic [7:0]         code;
  logic [7:0]         diff;
  logic               in_table;
  logic               printable;
  logic signed [19:0] pen_x_eff, pen_y_eff, line_x_eff;
  logic [21:0]        nl_step;
  logic signed [23:0] nl_add;

  logic [IDX_W-1:0]   rd_addr;
  logic               ram_we;
  glyph_t             wr_glyph;
  logic [$bits(glyph_t)-1:0] rd_data;
  glyph_t             g;

  logic signed [12:0] s_sx;
  logic signed [12:0] offy_adj;
  logic signed [11:0] dx, dy;
  logic signed [15:0] dx16, dy16;

  // products, registered between the read and the add step
  logic signed [24:0] offx_p_r;
  logic signed [25:0] offy_p_r;
  logic signed [28:0] w_p_r, h_p_r;
  logic [23:0]        adv_p_r;
  logic [10:0]        ax0_r, ay0_r, ax1_r, ay1_r;

  logic signed [23:0] x0, y0, x1, y1, adv_sum;

  assign take    = (state_r == ST_IDLE) && ibuf_vld_r;
  assign in_full = ibuf_vld_r && !take;

  // decode of the buffered request
  assign code      = ibuf_r.char_code;
  assign diff      = code - FIRST_CODE;
  assign in_table  = (code >= FIRST_CODE) && (int'(diff) < GLYPH_COUNT);
  assign printable = in_table && (code <= LAST_CODE);

  assign pen_x_eff  = ibuf_r.first_of_string ? ibuf_r.origin_x : pen_x_r;
  assign pen_y_eff  = ibuf_r.first_of_string ? ibuf_r.origin_y : pen_y_r;
  assign line_x_eff = ibuf_r.first_of_string ? ibuf_r.origin_x : line_x_r;

  // 36.0 * scale = 576 * scale, nonnegative so the floor is a plain shift
  assign nl_step = 22'({scale, 9'b0}) + 22'({scale, 6'b0});
  assign nl_add  = $signed(24'(nl_step >> 8));

  // glyph table
  assign ram_we         = take && (ibuf_r.operation == OP_LOAD) && in_table;
  assign wr_glyph.ax0   = clamp_atlas(ibuf_r.atlas_x0);
  assign wr_glyph.ay0   = clamp_atlas(ibuf_r.atlas_y0);
  assign wr_glyph.ax1   = clamp_atlas(ibuf_r.atlas_x1);
  assign wr_glyph.ay1   = clamp_atlas(ibuf_r.atlas_y1);
  assign wr_glyph.off_x = ibuf_r.offset_x;
  assign wr_glyph.off_y = ibuf_r.offset_y;
  assign wr_glyph.adv   = ibuf_r.advance;
  assign rd_addr        = IDX_W'(printable ? diff : SUBST_IDX);

  gqv_ram #(
    .WIDTH ($bits(glyph_t)),
    .DEPTH (GLYPH_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(diff)),
    .wdata (wr_glyph),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // a missing substitute reads as an all-zero glyph
  assign g        = zero_r ? '0 : glyph_t'(rd_data);
  assign s_sx     = $signed({1'b0, scale});
  assign offy_adj = 13'(g.off_y) + TOP_SHIFT_Q4;
  assign dx       = $signed({1'b0, g.ax1}) - $signed({1'b0, g.ax0});
  assign dy       = $signed({1'b0, g.ay1}) - $signed({1'b0, g.ay0});
  assign dx16     = {dx, 4'b0};
  assign dy16     = {dy, 4'b0};

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      offx_p_r <= g.off_x * s_sx;
      offy_p_r <= offy_adj * s_sx;
      w_p_r    <= dx16 * s_sx;
      h_p_r    <= dy16 * s_sx;
      adv_p_r  <= g.adv * scale;
      ax0_r    <= g.ax0;
      ay0_r    <= g.ay0;
      ax1_r    <= g.ax1;
      ay1_r    <= g.ay1;
    end
    if (in_push && !in_full) begin
      ibuf_r <= in_item;
    end
  end

  // floor of each product by arithmetic shift, sums kept exact before saturation
  assign x0      = 24'(pen_x_r) + 24'(offx_p_r >>> 8);
  assign y0      = 24'(pen_y_r) + 24'(offy_p_r >>> 8);
  assign x1      = x0 + 24'(w_p_r >>> 8);
  assign y1      = y0 + 24'(h_p_r >>> 8);
  assign adv_sum = 24'(pen_x_r) + $signed(24'(adv_p_r >> 8));

  assign q_quad.x0  = sat_pos(x0);
  assign q_quad.y0  = sat_pos(y0);
  assign q_quad.x1  = sat_pos(x1);
  assign q_quad.y1  = sat_pos(y1);
  assign q_quad.ax0 = ax0_r;
  assign q_quad.ay0 = ay0_r;
  assign q_quad.ax1 = ax1_r;
  assign q_quad.ay1 = ay1_r;

  always_comb begin
    state_nxt    = state_r;
    pen_x_nxt    = pen_x_r;
    pen_y_nxt    = pen_y_r;
    line_x_nxt   = line_x_r;
    zero_nxt     = zero_r;
    q_push       = 1'b0;
    ibuf_vld_nxt = ibuf_vld_r;

    if (in_push && !in_full) begin
      ibuf_vld_nxt = 1'b1;
    end else if (take) begin
      ibuf_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (take && (ibuf_r.operation == OP_TEXT)) begin
          pen_x_nxt  = pen_x_eff;
          pen_y_nxt  = pen_y_eff;
          line_x_nxt = line_x_eff;
          if (code == NEWLINE_CODE) begin
            pen_x_nxt = line_x_eff;
            pen_y_nxt = sat_pos(24'(pen_y_eff) + nl_add);
          end else if (code != CR_CODE) begin
            zero_nxt  = !printable && (int'(SUBST_IDX) >= GLYPH_COUNT);
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // hold the quad until the queue has room
        if (!q_full) begin
          q_push    = 1'b1;
          pen_x_nxt = sat_pos(adv_sum);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ibuf_vld_r <= 1'b0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      line_x_r   <= '0;
      zero_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ibuf_vld_r <= ibuf_vld_nxt;
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
      line_x_r   <= line_x_nxt;
      zero_r     <= zero_nxt;
    end
  end
endmodule

// ===== hw/rtl/gqv_queue.sv =====
// ----------------------------------------------------------------------------
// gqv_queue: short quad queue
// Decouples quad geometry from vertex emission.
// ----------------------------------------------------------------------------
module gqv_queue import gqv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  quad_t push_quad,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output quad_t head
);
  quad_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (int'(cnt_r) == QUEUE_DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end
endmodule

// ===== hw/rtl/gqv_back.sv =====
// ----------------------------------------------------------------------------
// gqv_back: vertex emitter
// Walks each quad through its six corners into a registered result slot.
// ----------------------------------------------------------------------------
module gqv_back import gqv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  quad_t       q_head,
  output logic        q_pop,
  input  logic [31:0] color,
  output logic        out_empty,
  input  logic        out_pop,
  output vertex_t     out_vertex
);
  logic       o_vld_r, o_vld_nxt;
  vertex_t    vert_r;
  quad_t      quad_r;
  logic       busy_r, busy_nxt;
  logic [2:0] corner_r, corner_nxt;
  logic       load, last_emit;
  logic       use_x1, use_y1;
  vertex_t    vert_nxt;

  assign load      = busy_r && (!o_vld_r || out_pop);
  assign last_emit = load && (corner_r == CORNER_BR);
  assign q_pop     = !q_empty && (!busy_r || last_emit);

  always_comb begin
    case (corner_r)
      CORNER_TL:  begin use_x1 = 1'b0; use_y1 = 1'b0; end
      CORNER_BL:  begin use_x1 = 1'b0; use_y1 = 1'b1; end
      CORNER_TR:  begin use_x1 = 1'b1; use_y1 = 1'b0; end
      CORNER_TR2: begin use_x1 = 1'b1; use_y1 = 1'b0; end
      CORNER_BL2: begin use_x1 = 1'b0; use_y1 = 1'b1; end
      CORNER_BR:  begin use_x1 = 1'b1; use_y1 = 1'b1; end
      default:    begin use_x1 = 1'b0; use_y1 = 1'b0; end
    endcase
  end

  always_comb begin
    vert_nxt.pos_x        = use_x1 ? quad_r.x1  : quad_r.x0;
    vert_nxt.pos_y        = use_y1 ? quad_r.y1  : quad_r.y0;
    vert_nxt.tex_u        = use_x1 ? quad_r.ax1 : quad_r.ax0;
    vert_nxt.tex_v        = use_y1 ? quad_r.ay1 : quad_r.ay0;
    vert_nxt.color        = color;
    vert_nxt.corner_index = corner_r;
    vert_nxt.last         = (corner_r == CORNER_BR);
  end

  always_comb begin
    busy_nxt   = busy_r;
    corner_nxt = corner_r;
    o_vld_nxt  = o_vld_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (last_emit) begin
      busy_nxt = 1'b0;
    end
    if (last_emit) begin
      corner_nxt = CORNER_TL;
    end else if (load) begin
      corner_nxt = corner_r + 3'd1;
    end
    if (load) begin
      o_vld_nxt = 1'b1;
    end else if (out_pop) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quad_r <= q_head;
    end
    if (load) begin
      vert_r <= vert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r  <= 1'b0;
      busy_r   <= 1'b0;
      corner_r <= CORNER_TL;
    end else begin
      o_vld_r  <= o_vld_nxt;
      busy_r   <= busy_nxt;
      corner_r <= corner_nxt;
    end
  end

  assign out_empty  = !o_vld_r;
  assign out_vertex = vert_r;
endmodule

// ===== hw/rtl/glyph_quad_vertex_gen.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_vertex_gen: bitmap font text to quad vertex generator
// Loads a glyph table, then turns text bytes into six-vertex glyph quads.
// ----------------------------------------------------------------------------
// Usage: load the glyph table first (operation 0, one request per character
// code 32..127; loads outside the table are dropped), then stream text bytes
// (operation 1). Each printable byte yields six vertices TL, BL, TR, TR, BL,
// BR with last set on the sixth; newline and carriage return yield none, and
// unmapped bytes draw as '?'. A table load or a control byte is done in the
// front end's idle state; a printable byte goes on through the table read,
// multiply, and add and saturate steps. The vertex port emits one vertex per
// cycle while out_pop keeps the result slot free. A two-entry quad queue sits
// between geometry and vertex emission, and a one-request input buffer
// accepts the next byte while the previous one is still in flight. Write
// scale and packed_color only while the block is drained.
// ----------------------------------------------------------------------------
module glyph_quad_vertex_gen import gqv_pkg::*; #(
  parameter int GLYPH_COUNT = 96,
  parameter int ATLAS_SIZE  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input request channel
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_operation,
  input  logic [7:0]         in_char_code,
  input  logic               in_first_of_string,
  input  logic signed [19:0] in_origin_x,
  input  logic signed [19:0] in_origin_y,
  input  logic [10:0]        in_atlas_x0,
  input  logic [10:0]        in_atlas_y0,
  input  logic [10:0]        in_atlas_x1,
  input  logic [10:0]        in_atlas_y1,
  input  logic signed [11:0] in_offset_x,
  input  logic signed [11:0] in_offset_y,
  input  logic [11:0]        in_advance,
  // result channel
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [19:0] out_pos_x,
  output logic signed [19:0] out_pos_y,
  output logic [10:0]        out_tex_u,
  output logic [10:0]        out_tex_v,
  output logic [31:0]        out_color,
  output logic [2:0]         out_corner_index,
  output logic               out_last,
  // configuration write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);
  logic [11:0] scale_r;
  logic [31:0] color_r;
  item_t       item;
  logic        q_push, q_full, q_pop, q_empty;
  quad_t       q_in, q_head;
  vertex_t     vert;

  // configuration registers; the user must change values only while drained, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 12'd256;
      color_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_r <= cfg_wdata[11:0];
        REG_COLOR: color_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign item.operation       = in_operation;
  assign item.char_code       = in_char_code;
  assign item.first_of_string = in_first_of_string;
  assign item.origin_x        = in_origin_x;
  assign item.origin_y        = in_origin_y;
  assign item.atlas_x0        = in_atlas_x0;
  assign item.atlas_y0        = in_atlas_y0;
  assign item.atlas_x1        = in_atlas_x1;
  assign item.atlas_y1        = in_atlas_y1;
  assign item.offset_x        = in_offset_x;
  assign item.offset_y        = in_offset_y;
  assign item.advance         = in_advance;

  // front: request buffer, glyph table, pen and quad geometry
  gqv_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .ATLAS_SIZE  (ATLAS_SIZE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (item),
    .scale   (scale_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_quad  (q_in)
  );

  // quad queue: lets geometry run ahead while vertices drain
  gqv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_quad (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: six vertices per quad into the result register
  gqv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .color      (color_r),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_vertex (vert)
  );

  assign out_pos_x        = vert.pos_x;
  assign out_pos_y        = vert.pos_y;
  assign out_tex_u        = vert.tex_u;
  assign out_tex_v        = vert.tex_v;
  assign out_color        = vert.color;
  assign out_corner_index = vert.corner_index;
  assign out_last         = vert.last;
endmodule
